@@ design/stable_priority_sort_assert.svh @@
// Assertion macros shared by the sorter RTL.
`ifndef STABLE_PRIORITY_SORT_ASSERT_SVH
`define STABLE_PRIORITY_SORT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sps_pkg.sv @@
// Fixed field widths and field types of the priority sorter.
package sps_pkg;

	localparam int PRIO_W = 3;
	localparam int TAG_W  = 16;
	localparam int DATA_W = 24;

	typedef logic [PRIO_W-1:0] prio_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [DATA_W-1:0] data_t;

endpackage

@@ design/stable_priority_sort.sv @@
// Stable batch sorter by priority: record store, insertion sort sequencer, output register.
//
//  channel | dir | handshake          | tdata (low bit up)                 | side bands
//  --------+-----+--------------------+------------------------------------+----------------------
//  s_*     | in  | s_tvalid/s_tready  | priority_req[2:0] record_tag[18:3] | tlast = last
//  m_*     | out | m_tvalid/m_tready  | record_tag_res[15:0] prio[18:16]   | tlast = last_res,
//          |     |                    |                                    | tuser = overflow
//
// Loading accepts one word per cycle while s_tready is high. After the last word the store
// is sorted in place through its single read and single write port: a fetch, then for each
// record after the first a step to latch it, one compare step per position it moves down
// and one more to compare against its resting neighbor or to place it at the front (a single
// record skips the sort). Emission then reads each result from memory and loads it into the
// output register, waiting while m_tready holds a previous result there.
// s_tready is low from the accepted last word until the final result is in the output register.
// Reset clears count, drop flag and control; the store itself needs no clearing.
module stable_priority_sort #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sps_pkg::data_t       s_tdata,   // priority_req[2:0], record_tag[18:3], zero pad
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output sps_pkg::data_t       m_tdata,   // record_tag_res[15:0], priority_res[18:16], zero pad
	output logic                 m_tlast,
	output logic                 m_tuser    // overflow
);

	// Stored tag width: only the low TAG_BITS bits (at most 16) of the 16-bit tag are kept.
	localparam int TW = (TAG_BITS < sps_pkg::TAG_W) ? TAG_BITS : sps_pkg::TAG_W;
	localparam int EW = sps_pkg::PRIO_W + TW;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW-1:0] ONE_A = AW'(1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_HOLD,
		ST_CMP,
		ST_PLACE,
		ST_ERD,
		ST_EOUT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           dropped_q;
	logic [AW-1:0]  i_q;        // record being inserted
	logic [AW-1:0]  k_q;        // hole position
	logic [AW-1:0]  e_q;        // emit index
	logic [EW-1:0]  held_q;
	logic [EW-1:0]  rd_q;
	logic           m_tvalid_q;
	sps_pkg::data_t m_tdata_q;
	logic           m_tlast_q;
	logic           m_tuser_q;

	logic [EW-1:0]  mem_q [CAPACITY];

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [EW-1:0]  wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;

	logic           in_acc;
	logic           full;
	logic [AW-1:0]  n_m1;
	logic           rd_gt;      // fetched neighbor sorts after the held record
	logic           sort_done;
	logic           out_free;
	logic           e_last;

	assign s_tready  = (state_q == ST_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == CAP_C);
	assign n_m1      = AW'(count_q - CW'(1));
	assign rd_gt     = rd_q[EW-1 -: sps_pkg::PRIO_W] > held_q[EW-1 -: sps_pkg::PRIO_W];
	assign sort_done = (i_q == n_m1);
	assign out_free  = !m_tvalid_q || m_tready;
	assign e_last    = (e_q == n_m1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// Memory port control for each sequencer step.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = held_q;
		rd_en   = 1'b0;
		rd_addr = i_q;
		unique case (state_q)
			ST_LOAD: begin
				wr_en   = in_acc && !full;
				wr_addr = count_q[AW-1:0];
				wr_data = {s_tdata[sps_pkg::PRIO_W-1:0], s_tdata[sps_pkg::PRIO_W +: TW]};
			end
			ST_FETCH: begin
				rd_en = 1'b1;
			end
			ST_HOLD: begin
				rd_en   = 1'b1;
				rd_addr = i_q - ONE_A;
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (rd_gt) begin
					// shift neighbor up, look one further down
					wr_data = rd_q;
					rd_en   = (k_q != ONE_A);
					rd_addr = k_q - ONE_A - ONE_A;
				end else begin
					rd_en   = !sort_done;
					rd_addr = i_q + ONE_A;
				end
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				rd_en   = !sort_done;
				rd_addr = i_q + ONE_A;
			end
			ST_ERD: begin
				rd_en   = 1'b1;
				rd_addr = e_q;
			end
			ST_EOUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			i_q        <= '0;
			k_q        <= '0;
			e_q        <= '0;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			// output slot empties on handshake; ST_EOUT reloads it itself
			if (m_tvalid_q && m_tready && state_q != ST_EOUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (s_tlast) begin
							i_q <= ONE_A;
							e_q <= '0;
							// single record: nothing to sort
							state_q <= (count_q == '0) ? ST_ERD : ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					held_q  <= rd_q;
					k_q     <= i_q;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (rd_gt) begin
						k_q <= k_q - ONE_A;
						if (k_q == ONE_A) begin
							state_q <= ST_PLACE;
						end
					end else if (sort_done) begin
						state_q <= ST_ERD;
					end else begin
						i_q     <= i_q + ONE_A;
						state_q <= ST_HOLD;
					end
				end
				ST_PLACE: begin
					if (sort_done) begin
						state_q <= ST_ERD;
					end else begin
						i_q     <= i_q + ONE_A;
						state_q <= ST_HOLD;
					end
				end
				ST_ERD: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= sps_pkg::DATA_W'({
							sps_pkg::prio_t'(rd_q[EW-1 -: sps_pkg::PRIO_W]),
							sps_pkg::tag_t'(rd_q[TW-1:0])});
						m_tlast_q  <= e_last;
						m_tuser_q  <= dropped_q;
						if (e_last) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							e_q     <= e_q + ONE_A;
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`include "stable_priority_sort_assert.svh"

	`SPS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C, "record count above capacity")
	`SPS_ASSERT_NOW(a_hole_range, state_q == ST_CMP, (k_q != '0) && (k_q <= i_q),
		"insertion hole outside sorted prefix")
	`SPS_ASSERT_NEXT(a_last_busy, in_acc && s_tlast, !s_tready,
		"input still open after batch end")
	`SPS_ASSERT_NEXT(a_batch_clear, state_q == ST_EOUT && out_free && e_last,
		s_tready && (count_q == '0) && !dropped_q && m_tvalid && m_tlast,
		"batch state not cleared after final result")

endmodule
